// ----- rtl/core/cdr_pkg.sv -----
package cdr_pkg;

	// Action codes carried in the action field of an input beat.
	localparam logic [2:0] ACT_NEXT_DAY   = 3'd0;
	localparam logic [2:0] ACT_LOAD_DATE  = 3'd1;
	localparam logic [2:0] ACT_LOAD_SIG   = 3'd2;
	localparam logic [2:0] ACT_FIRST_PREV = 3'd3;
	localparam logic [2:0] ACT_LAST_PREV  = 3'd4;
	localparam logic [2:0] ACT_FIRST_CUR  = 3'd5;
	localparam logic [2:0] ACT_LAST_CUR   = 3'd6;
	localparam logic [2:0] ACT_NONE       = 3'd7;

	localparam logic [13:0] YEAR_MAX  = 14'd9999;
	localparam logic [6:0]  MONTH_MAX = 7'd99;
	localparam logic [6:0]  CENT_MAX  = 7'd99;
	localparam logic [6:0]  YY_MAX    = 7'd99;
	localparam logic [6:0]  MONTH_JAN = 7'd1;
	localparam logic [6:0]  MONTH_DEC = 7'd12;
	localparam logic [6:0]  DAY_FIRST = 7'd1;
	localparam logic [6:0]  HUNDRED   = 7'd100;
	localparam logic [13:0] TEN_K     = 14'd10000;

	// x / 100 == (x * 20972) >> 21 for every x below 2**14.
	localparam logic [14:0] DIV100_MUL   = 15'd20972;
	localparam int          DIV100_SHIFT = 21;
	// x / 10000 == (x * 219902326) >> 41 for every x below 2**27.
	localparam logic [27:0] DIV10K_MUL   = 28'd219902326;
	localparam int          DIV10K_SHIFT = 41;

	typedef struct packed {
		logic [2:0]  action;
		logic [13:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [26:0] signature_in;
	} in_t;

	typedef struct packed {
		logic [13:0] year_out;
		logic [6:0]  month_out;
		logic [6:0]  day_out;
		logic [26:0] signature_out;
		logic [4:0]  last_day;
		logic        leap_year;
		logic        date_valid;
	} out_t;

	// A date with its year also split into century and year of century.
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  cent;
		logic [6:0]  yy;
		logic [6:0]  month;
		logic [6:0]  day;
	} cdr_date_t;

	// Decoded operands handed to the date register.
	typedef struct packed {
		logic [2:0] action;
		cdr_date_t  date;
	} cdr_load_t;

	// Leap rule on the split year: year % 4 equals yy % 4, and a century
	// year is a leap year only when the century is a multiple of four.
	function automatic logic leap_of(input logic [6:0] cent, input logic [6:0] yy);
		logic leap;
		if (yy == '0) begin
			leap = (cent[1:0] == 2'b00);
		end else begin
			leap = (yy[1:0] == 2'b00);
		end
		return leap;
	endfunction

	function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
		logic [4:0] len;
		case (month) inside
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
			7'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/core/calendar_date_register_unit.sv -----
// Gregorian calendar date register.
// Input channel: item_valid, item_stall and the item beat (action, year_in,
// month_in, day_in, signature_in). Output channel: result_valid,
// result_stall and the result beat (stored date, its YYYYMMDD signature, the
// last day of its month, leap flag, validity flag). Every input beat gives
// exactly one result beat, in order.
// One beat is taken every cycle while item_stall is low. Five stages unpack
// the decimal signature and split the year into century and year of century
// with constant reciprocal multiplies, one stage holds the date register
// itself, and two stages form the signature and the month facts of the new
// date.
// Reset empties the pipeline and sets the stored date to year 0, month 0,
// day 0. When the receiver stalls, the stages behind the waiting result
// keep filling bubbles; item_stall rises only once every stage holds a beat,
// and the date register does not move while its own result waits.
module calendar_date_register_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  cdr_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output cdr_pkg::out_t result
);

	// Decoded operands from the front pipeline into the date register.
	logic               ld_valid;
	logic               ld_stall;
	cdr_pkg::cdr_load_t ld;

	// Date after each beat, from the date register into the report stages.
	logic               dt_valid;
	logic               dt_stall;
	cdr_pkg::cdr_date_t dt;

	// Signature unpacking, year saturation and century split.
	cdr_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.ld_valid   (ld_valid),
		.ld_stall   (ld_stall),
		.ld         (ld)
	);

	// The date register: next day, loads and month-relative settings.
	cdr_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (ld_valid),
		.ld_stall (ld_stall),
		.ld       (ld),
		.dt_valid (dt_valid),
		.dt_stall (dt_stall),
		.dt       (dt)
	);

	// Signature, month length, leap and validity of the stored date.
	cdr_report u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.dt_valid     (dt_valid),
		.dt_stall     (dt_stall),
		.dt           (dt),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- rtl/core/cdr_decode.sv -----
module cdr_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  cdr_pkg::in_t       item,
	output logic               ld_valid,
	input  logic               ld_stall,
	output cdr_pkg::cdr_load_t ld
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic hold_1, hold_2, hold_3, hold_4, hold_5;

	cdr_pkg::in_t item_s1;

	logic [2:0]  act_s2, act_s3, act_s4;
	logic [3:0]  mon_s2, mon_s3, mon_s4;
	logic [4:0]  day_s2, day_s3, day_s4;
	logic [13:0] yin_s2, yin_s3, yin_s4;
	logic [7:0]  cin_s2, cin_s3, cin_s4;
	logic [26:0] sig_s2;
	logic [13:0] qy_s2, qy_s3, qy_s4;
	logic [6:0]  yyin_s3, yyin_s4;
	logic [7:0]  cq_s3, cq_s4;
	logic [13:0] rem_s3, rem_s4;
	logic [6:0]  yyq_s4;
	logic [6:0]  mq_s4;

	cdr_pkg::cdr_load_t ld_s5;

	logic [54:0] sig_prod;
	logic [28:0] yin_prod;
	logic [13:0] cin100;
	logic [13:0] yy_diff;
	logic [28:0] cq_prod;
	logic [26:0] q10k;
	logic [26:0] rem_diff;
	logic [13:0] cq100;
	logic [13:0] yyq_diff;
	logic [28:0] mq_prod;
	logic [13:0] mq100;
	logic [13:0] dd_diff;
	logic        sat_in, sat_q;
	cdr_pkg::cdr_load_t ld_nxt;

	assign hold_5 = v_s5 && ld_stall;
	assign hold_4 = v_s4 && hold_5;
	assign hold_3 = v_s3 && hold_4;
	assign hold_2 = v_s2 && hold_3;
	assign hold_1 = v_s1 && hold_2;
	assign item_stall = hold_1;

	assign sig_prod = 55'(item_s1.signature_in) * 55'(cdr_pkg::DIV10K_MUL);
	assign yin_prod = 29'(item_s1.year_in) * 29'(cdr_pkg::DIV100_MUL);

	assign cin100   = 14'(cin_s2) * 14'(cdr_pkg::HUNDRED);
	assign yy_diff  = yin_s2 - cin100;
	assign cq_prod  = 29'(qy_s2) * 29'(cdr_pkg::DIV100_MUL);
	assign q10k     = 27'(qy_s2) * 27'(cdr_pkg::TEN_K);
	assign rem_diff = sig_s2 - q10k;

	assign cq100    = 14'(cq_s3) * 14'(cdr_pkg::HUNDRED);
	assign yyq_diff = qy_s3 - cq100;
	assign mq_prod  = 29'(rem_s3) * 29'(cdr_pkg::DIV100_MUL);

	assign mq100   = 14'(mq_s4) * 14'(cdr_pkg::HUNDRED);
	assign dd_diff = rem_s4 - mq100;
	assign sat_in  = (yin_s4 > cdr_pkg::YEAR_MAX);
	assign sat_q   = (qy_s4 > cdr_pkg::YEAR_MAX);

	always_comb begin
		ld_nxt.action = act_s4;
		if (act_s4 == cdr_pkg::ACT_LOAD_SIG) begin
			ld_nxt.date.year  = sat_q ? cdr_pkg::YEAR_MAX : qy_s4;
			ld_nxt.date.cent  = sat_q ? cdr_pkg::CENT_MAX : cq_s4[6:0];
			ld_nxt.date.yy    = sat_q ? cdr_pkg::YY_MAX : yyq_s4;
			ld_nxt.date.month = mq_s4;
			ld_nxt.date.day   = dd_diff[6:0];
		end else begin
			ld_nxt.date.year  = sat_in ? cdr_pkg::YEAR_MAX : yin_s4;
			ld_nxt.date.cent  = sat_in ? cdr_pkg::CENT_MAX : cin_s4[6:0];
			ld_nxt.date.yy    = sat_in ? cdr_pkg::YY_MAX : yyin_s4;
			ld_nxt.date.month = 7'(mon_s4);
			ld_nxt.date.day   = 7'(day_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (!hold_1) v_s1 <= item_valid;
			if (!hold_2) v_s2 <= v_s1;
			if (!hold_3) v_s3 <= v_s2;
			if (!hold_4) v_s4 <= v_s3;
			if (!hold_5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_1) begin
			item_s1 <= item;
		end
		if (!hold_2) begin
			act_s2 <= item_s1.action;
			mon_s2 <= item_s1.month_in;
			day_s2 <= item_s1.day_in;
			yin_s2 <= item_s1.year_in;
			sig_s2 <= item_s1.signature_in;
			cin_s2 <= yin_prod[cdr_pkg::DIV100_SHIFT +: 8];
			qy_s2  <= sig_prod[cdr_pkg::DIV10K_SHIFT +: 14];
		end
		if (!hold_3) begin
			act_s3  <= act_s2;
			mon_s3  <= mon_s2;
			day_s3  <= day_s2;
			yin_s3  <= yin_s2;
			cin_s3  <= cin_s2;
			yyin_s3 <= yy_diff[6:0];
			qy_s3   <= qy_s2;
			cq_s3   <= cq_prod[cdr_pkg::DIV100_SHIFT +: 8];
			rem_s3  <= rem_diff[13:0];
		end
		if (!hold_4) begin
			act_s4  <= act_s3;
			mon_s4  <= mon_s3;
			day_s4  <= day_s3;
			yin_s4  <= yin_s3;
			cin_s4  <= cin_s3;
			yyin_s4 <= yyin_s3;
			qy_s4   <= qy_s3;
			cq_s4   <= cq_s3;
			yyq_s4  <= yyq_diff[6:0];
			rem_s4  <= rem_s3;
			mq_s4   <= mq_prod[cdr_pkg::DIV100_SHIFT +: 7];
		end
		if (!hold_5) begin
			ld_s5 <= ld_nxt;
		end
	end

	assign ld_valid = v_s5;
	assign ld       = ld_s5;

`ifndef ASSERT_OFF
	a_load_year_split: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (ld_s5.date.year <= cdr_pkg::YEAR_MAX) &&
			(14'(ld_s5.date.cent) * 14'd100 + 14'(ld_s5.date.yy) == ld_s5.date.year))
		else $error("decoded year does not match its century split");
`endif

endmodule

// ----- rtl/core/cdr_state.sv -----
module cdr_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ld_valid,
	output logic               ld_stall,
	input  cdr_pkg::cdr_load_t ld,
	output logic               dt_valid,
	input  logic               dt_stall,
	output cdr_pkg::cdr_date_t dt
);

	cdr_pkg::cdr_date_t date_q;
	logic               v_q;

	logic [2:0]  act_sel;
	logic        leap_cur;
	logic [4:0]  len_cur;
	logic [7:0]  day_inc;
	logic [13:0] inc_year;
	logic [6:0]  inc_cent, inc_yy;
	logic [13:0] pm_year;
	logic [6:0]  pm_cent, pm_yy, pm_month;
	logic [4:0]  pm_len, cur_len;
	cdr_pkg::cdr_date_t nxt;

	assign ld_stall = v_q && dt_stall;
	assign act_sel  = ld_valid ? ld.action : cdr_pkg::ACT_NONE;

	always_comb begin
		leap_cur = cdr_pkg::leap_of(date_q.cent, date_q.yy);
		len_cur  = cdr_pkg::month_len(date_q.month, leap_cur);
		day_inc  = {1'b0, date_q.day} + 8'd1;

		// Next year of the stored date, held at the top year.
		inc_year = date_q.year;
		inc_cent = date_q.cent;
		inc_yy   = date_q.yy;
		if (date_q.year < cdr_pkg::YEAR_MAX) begin
			inc_year = date_q.year + 14'd1;
			if (date_q.yy == cdr_pkg::YY_MAX) begin
				inc_yy   = '0;
				inc_cent = date_q.cent + 7'd1;
			end else begin
				inc_yy = date_q.yy + 7'd1;
			end
		end

		// Month before the given one; January and month zero fall back to
		// December of the year before, which holds at year zero.
		pm_year  = ld.date.year;
		pm_cent  = ld.date.cent;
		pm_yy    = ld.date.yy;
		pm_month = cdr_pkg::MONTH_DEC;
		if (ld.date.month > cdr_pkg::MONTH_JAN) begin
			pm_month = ld.date.month - 7'd1;
		end else if (ld.date.year != '0) begin
			pm_year = ld.date.year - 14'd1;
			if (ld.date.yy == '0) begin
				pm_yy   = cdr_pkg::YY_MAX;
				pm_cent = ld.date.cent - 7'd1;
			end else begin
				pm_yy = ld.date.yy - 7'd1;
			end
		end
		pm_len  = cdr_pkg::month_len(pm_month, cdr_pkg::leap_of(pm_cent, pm_yy));
		cur_len = cdr_pkg::month_len(ld.date.month,
			cdr_pkg::leap_of(ld.date.cent, ld.date.yy));

		nxt = date_q;
		unique case (act_sel) inside
			cdr_pkg::ACT_NEXT_DAY: begin
				if (day_inc <= {3'b000, len_cur}) begin
					nxt.day = day_inc[6:0];
				end else if (date_q.month == cdr_pkg::MONTH_DEC) begin
					nxt.year  = inc_year;
					nxt.cent  = inc_cent;
					nxt.yy    = inc_yy;
					nxt.month = cdr_pkg::MONTH_JAN;
					nxt.day   = cdr_pkg::DAY_FIRST;
				end else begin
					if (date_q.month < cdr_pkg::MONTH_MAX) begin
						nxt.month = date_q.month + 7'd1;
					end
					nxt.day = cdr_pkg::DAY_FIRST;
				end
			end
			cdr_pkg::ACT_LOAD_DATE, cdr_pkg::ACT_LOAD_SIG: begin
				nxt = ld.date;
			end
			cdr_pkg::ACT_FIRST_PREV, cdr_pkg::ACT_LAST_PREV: begin
				nxt.year  = pm_year;
				nxt.cent  = pm_cent;
				nxt.yy    = pm_yy;
				nxt.month = pm_month;
				nxt.day   = (act_sel == cdr_pkg::ACT_FIRST_PREV) ?
					cdr_pkg::DAY_FIRST : {2'b00, pm_len};
			end
			cdr_pkg::ACT_FIRST_CUR, cdr_pkg::ACT_LAST_CUR: begin
				nxt.year  = ld.date.year;
				nxt.cent  = ld.date.cent;
				nxt.yy    = ld.date.yy;
				nxt.month = ld.date.month;
				nxt.day   = (act_sel == cdr_pkg::ACT_FIRST_CUR) ?
					cdr_pkg::DAY_FIRST : {2'b00, cur_len};
			end
			cdr_pkg::ACT_NONE: begin
				nxt = date_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= 1'b0;
			date_q <= '0;
		end else begin
			if (!ld_stall) begin
				v_q <= ld_valid;
				if (ld_valid) begin
					date_q <= nxt;
				end
			end
		end
	end

	assign dt_valid = v_q;
	assign dt       = date_q;

`ifndef ASSERT_OFF
	a_year_split: assert property (@(posedge clk) disable iff (!arst_n)
		14'(date_q.cent) * 14'd100 + 14'(date_q.yy) == date_q.year)
		else $error("stored year does not match its century split");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(date_q.year <= cdr_pkg::YEAR_MAX) && (date_q.month <= cdr_pkg::MONTH_MAX) &&
		(date_q.day <= 7'd99))
		else $error("stored date out of range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dt_valid && dt_stall |=> $stable(date_q))
		else $error("stored date changed while its result was stalled");

	a_next_day_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ld_valid && !ld_stall && (ld.action == cdr_pkg::ACT_NEXT_DAY) &&
		(date_q.day != '0) && ({2'b00, len_cur} >= date_q.day)
		|=> (date_q.day != '0) && ({2'b00, cdr_pkg::month_len(date_q.month,
			cdr_pkg::leap_of(date_q.cent, date_q.yy))} >= date_q.day))
		else $error("next day turned a valid date into an invalid one");
`endif

endmodule

// ----- rtl/core/cdr_report.sv -----
module cdr_report (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               dt_valid,
	output logic               dt_stall,
	input  cdr_pkg::cdr_date_t dt,
	output logic               result_valid,
	input  logic               result_stall,
	output cdr_pkg::out_t      result
);

	logic v_s1, v_s2;
	logic hold_1, hold_2;

	logic [26:0] yk_s1;
	logic [13:0] md_s1;
	logic [13:0] year_s1;
	logic [6:0]  month_s1, day_s1;
	logic [4:0]  last_s1;
	logic        leap_s1, ok_s1;

	cdr_pkg::out_t res_s2;

	logic        leap_c;
	logic [4:0]  last_c;

	assign hold_2   = v_s2 && result_stall;
	assign hold_1   = v_s1 && hold_2;
	assign dt_stall = hold_1;

	assign leap_c = cdr_pkg::leap_of(dt.cent, dt.yy);
	assign last_c = cdr_pkg::month_len(dt.month, leap_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!hold_1) v_s1 <= dt_valid;
			if (!hold_2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_1) begin
			yk_s1    <= 27'(dt.year) * 27'(cdr_pkg::TEN_K);
			md_s1    <= 14'(dt.month) * 14'(cdr_pkg::HUNDRED) + 14'(dt.day);
			year_s1  <= dt.year;
			month_s1 <= dt.month;
			day_s1   <= dt.day;
			last_s1  <= last_c;
			leap_s1  <= leap_c;
			ok_s1    <= (dt.day != '0) && ({2'b00, last_c} >= dt.day);
		end
		if (!hold_2) begin
			res_s2.year_out      <= year_s1;
			res_s2.month_out     <= month_s1;
			res_s2.day_out       <= day_s1;
			res_s2.signature_out <= yk_s1 + 27'(md_s1);
			res_s2.last_day      <= last_s1;
			res_s2.leap_year     <= leap_s1;
			res_s2.date_valid    <= ok_s1;
		end
	end

	assign result_valid = v_s2;
	assign result       = res_s2;

`ifndef ASSERT_OFF
	a_valid_has_month: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.date_valid |-> (res_s2.last_day != '0) && (res_s2.day_out != '0))
		else $error("valid date reported without a month length");
`endif

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Run length and pacing. Each idling phase covers about a third of the run.
	localparam int RANDOM_BEATS = 1850;
	localparam int PHASE_A_END  = 650;
	localparam int PHASE_B_END  = 1300;
	// The long receiver hold-off starts once this many beats have gone in.
	localparam int HOLD_AT      = 1450;
	localparam int HOLD_CYCLES  = 300;
	// The drain waits a good deal longer than the latency of the block.
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	// One row of the directed table. When known is set, the expected result is
	// typed into the row. Otherwise the date predictor supplies it.
	typedef struct packed {
		logic [2:0]  act;
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [26:0] sig;
		bit          known;
		logic [13:0] want_year;
		logic [6:0]  want_month;
		logic [6:0]  want_day;
		logic [4:0]  want_last;
		bit          want_leap;
		bit          want_valid;
	} plan_row_t;

	// A beat waiting to be offered, together with the result it should cause
	// when that result is typed in rather than predicted.
	typedef struct {
		cdr_pkg::in_t  beat;
		bit            known;
		cdr_pkg::out_t want;
	} offer_t;

	localparam int PLAN_ROWS = 27;
	localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
		// Right after reset the stored date is all zero. Year 0 counts as a leap year.
		'{cdr_pkg::ACT_NONE,       0,     0,  0, 0,         1, 0,    0,  0,  0,  1, 0},
		// Next day from month 0: no day is valid, so the month steps to 1 and the day to 1.
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         1, 0,    1,  1,  31, 1, 1},
		// All input bits set: the year saturates to 9999 and month 15 has no last day.
		'{cdr_pkg::ACT_LOAD_DATE,  16383, 15, 31, 0,        1, 9999, 15, 31, 0,  0, 0},
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         0, 0,    0,  0,  0,  0, 0},
		// The largest decimal signature gives month 99 and day 99.
		'{cdr_pkg::ACT_LOAD_SIG,   0,     0,  0, 99999999,  1, 9999, 99, 99, 0,  0, 0},
		// The month is already at 99, so it stays there while the day becomes 1.
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         0, 0,    0,  0,  0,  0, 0},
		// Every signature bit set: the year part exceeds 9999 and saturates.
		'{cdr_pkg::ACT_LOAD_SIG,   0,     0,  0, 134217727, 0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_LOAD_SIG,   0,     0,  0, 0,         1, 0,    0,  0,  0,  1, 0},
		'{cdr_pkg::ACT_LOAD_DATE,  9999,  12, 31, 0,        1, 9999, 12, 31, 31, 0, 1},
		// Rolling over from the last day of year 9999 keeps the year at 9999.
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         1, 9999, 1,  1,  31, 0, 1},
		// 2000 is a leap year because it is divisible by 400. 1900 is not a leap year.
		'{cdr_pkg::ACT_LOAD_DATE,  2000,  2,  28, 0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_LOAD_DATE,  1900,  2,  28, 0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         0, 0,    0,  0,  0,  0, 0},
		// The previous month of January, year 0, is December and the year stays at 0.
		'{cdr_pkg::ACT_FIRST_PREV, 0,     1,  17, 0,        1, 0,    12, 1,  31, 1, 1},
		'{cdr_pkg::ACT_LAST_PREV,  0,     0,  31, 0,        0, 0,    0,  0,  0,  0, 0},
		// A today's month above 12 simply steps back by one.
		'{cdr_pkg::ACT_FIRST_PREV, 2024,  13, 5,  0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_LAST_PREV,  2024,  15, 31, 0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_LAST_PREV,  2024,  3,  9,  0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_FIRST_CUR,  2023,  7,  15, 0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_LAST_CUR,   2023,  2,  0,  0,        0, 0,    0,  0,  0,  0, 0},
		// The last day of month 0 or month 13 is day 0.
		'{cdr_pkg::ACT_LAST_CUR,   12000, 0,  3,  0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_LAST_CUR,   1,     13, 1,  0,        0, 0,    0,  0,  0,  0, 0},
		// The unused action leaves the date untouched.
		'{cdr_pkg::ACT_NONE,       5,     5,  5,  12345,    0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_LOAD_DATE,  2023,  4,  30, 0,        0, 0,    0,  0,  0,  0, 0},
		'{cdr_pkg::ACT_NEXT_DAY,   0,     0,  0, 0,         0, 0,    0,  0,  0,  0, 0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	cdr_pkg::in_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	cdr_pkg::out_t result;

	calendar_date_register_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The predictor's own copy of the stored date. It starts at the reset value.
	logic [13:0] cal_year = '0;
	logic [6:0]  cal_month = '0;
	logic [6:0]  cal_day = '0;

	offer_t        date_offers[$];
	cdr_pkg::out_t pending_dates[$];
	int     n_accepted = 0;
	int     n_errors = 0;
	int     n_cycles = 0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;

	function automatic bit is_leap_year(int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_days(int y, int m);
		int n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11: n = 30;
			2: n = is_leap_year(y) ? 29 : 28;
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic int clamp_year(int y);
		return (y > 9999) ? 9999 : y;
	endfunction

	// Builds a full result from a stored date. The flags and the last day are
	// taken from the caller.
	function automatic cdr_pkg::out_t date_result(int y, int m, int d, int last, bit leap,
		bit ok);
		cdr_pkg::out_t r;
		r.year_out      = y[13:0];
		r.month_out     = m[6:0];
		r.day_out       = d[6:0];
		r.signature_out = 27'(y * 10000 + m * 100 + d);
		r.last_day      = last[4:0];
		r.leap_year     = leap;
		r.date_valid    = ok;
		return r;
	endfunction

	// Applies one action to the predictor's date and returns the result it reports.
	function automatic cdr_pkg::out_t advance_calendar(cdr_pkg::in_t b);
		int y;
		int m;
		int d;
		int sig;
		int last;
		y = cal_year;
		m = cal_month;
		d = cal_day;
		sig = b.signature_in;
		case (b.action)
			cdr_pkg::ACT_NEXT_DAY: begin
				if (d + 1 <= month_days(y, m)) begin
					d = d + 1;
				end else if (m == 12) begin
					if (y < 9999) y = y + 1;
					m = 1;
					d = 1;
				end else begin
					if (m < 99) m = m + 1;
					d = 1;
				end
			end
			cdr_pkg::ACT_LOAD_DATE: begin
				y = clamp_year(b.year_in);
				m = b.month_in;
				d = b.day_in;
			end
			cdr_pkg::ACT_LOAD_SIG: begin
				y = clamp_year(sig / 10000);
				m = (sig % 10000) / 100;
				d = sig % 100;
			end
			cdr_pkg::ACT_FIRST_PREV, cdr_pkg::ACT_LAST_PREV: begin
				y = clamp_year(b.year_in);
				m = b.month_in;
				if (m > 1) begin
					m = m - 1;
				end else begin
					if (y > 0) y = y - 1;
					m = 12;
				end
				d = (b.action == cdr_pkg::ACT_FIRST_PREV) ? 1 : month_days(y, m);
			end
			cdr_pkg::ACT_FIRST_CUR, cdr_pkg::ACT_LAST_CUR: begin
				y = clamp_year(b.year_in);
				m = b.month_in;
				d = (b.action == cdr_pkg::ACT_FIRST_CUR) ? 1 : month_days(y, m);
			end
			default: begin
			end
		endcase
		cal_year = y[13:0];
		cal_month = m[6:0];
		cal_day = d[6:0];
		last = month_days(y, m);
		return date_result(y, m, d, last, is_leap_year(y), (d >= 1) && (d <= last));
	endfunction

	// Random years lean on the corners of the leap rule and on saturation.
	function automatic int pick_year();
		int y;
		case ($urandom_range(0, 9))
			0: y = 0;
			1: y = 9999;
			2: y = 1900;
			3: y = 2000;
			4: y = 2100;
			5: y = $urandom_range(10000, 16383);
			default: y = $urandom_range(0, 9999);
		endcase
		return y;
	endfunction

	// Draws one random beat. Most beats carry well-formed dates, often close
	// to a month end, so that runs of next-day actions cross month and year
	// boundaries. The rest carry raw bits.
	function automatic cdr_pkg::in_t random_beat();
		cdr_pkg::in_t b;
		int  pick;
		int  y;
		int  m;
		int  d;
		b.action       = cdr_pkg::ACT_NONE;
		b.year_in      = 14'($urandom);
		b.month_in     = 4'($urandom);
		b.day_in       = 5'($urandom);
		b.signature_in = 27'($urandom);
		y = pick_year();
		m = $urandom_range(1, 12);
		d = month_days(y, m) - $urandom_range(0, 2);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			b.action = cdr_pkg::ACT_NEXT_DAY;
		end else if (pick < 55) begin
			b.action = cdr_pkg::ACT_LOAD_DATE;
			if ($urandom_range(0, 4) != 0) begin
				b.year_in = y[13:0];
				b.month_in = m[3:0];
				b.day_in = d[4:0];
			end
		end else if (pick < 65) begin
			b.action = cdr_pkg::ACT_LOAD_SIG;
			if ($urandom_range(0, 3) != 0) b.signature_in = 27'(y * 10000 + m * 100 + d);
		end else if (pick < 95) begin
			b.action = 3'($urandom_range(cdr_pkg::ACT_FIRST_PREV, cdr_pkg::ACT_LAST_CUR));
			if ($urandom_range(0, 3) != 0) begin
				b.year_in = y[13:0];
				b.month_in = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : m[3:0];
			end
		end
		return b;
	endfunction

	// Idling is chosen by how far the run has got: first the sender idles more
	// rarely than the receiver, then the other way round, then neither idles.
	function automatic int sender_idle_pct();
		return (n_accepted < PHASE_A_END) ? 37 : (n_accepted < PHASE_B_END) ? 65 : 0;
	endfunction

	function automatic int receiver_idle_pct();
		return (n_accepted < PHASE_A_END) ? 65 : (n_accepted < PHASE_B_END) ? 37 : 0;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
		n_errors++;
	endtask

	// Sender. A beat that is stalled stays on the bus unchanged. Otherwise the
	// next beat is offered unless this cycle is picked as an idle cycle. The
	// predictor advances at the edge where the beat is accepted, so the
	// expected results queue up in the order the block has to return them.
	// Rows with a typed-in result still advance the predictor's date.
	always @(posedge clk) begin
		offer_t        taken;
		cdr_pkg::out_t pred;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				taken = date_offers.pop_front();
				pred = advance_calendar(taken.beat);
				pending_dates.push_back(taken.known ? taken.want : pred);
				n_accepted <= n_accepted + 1;
			end
			if (!(item_valid && item_stall)) begin
				if (date_offers.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					item_valid <= 1'b1;
					item <= date_offers[0].beat;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Once in the run it holds off for a long stretch, counted here
	// in cycles. The sender keeps offering beats during that stretch, so the
	// pipeline fills and item_stall rises.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
			end
		end
	end

	// Every accepted result is checked field by field against the oldest
	// expected date.
	always @(posedge clk) begin
		cdr_pkg::out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_dates.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				n_errors++;
			end else begin
				want = pending_dates.pop_front();
				if (result.year_out !== want.year_out)
					report_mismatch("year_out", result.year_out, want.year_out);
				if (result.month_out !== want.month_out)
					report_mismatch("month_out", result.month_out, want.month_out);
				if (result.day_out !== want.day_out)
					report_mismatch("day_out", result.day_out, want.day_out);
				if (result.signature_out !== want.signature_out)
					report_mismatch("signature_out", result.signature_out, want.signature_out);
				if (result.last_day !== want.last_day)
					report_mismatch("last_day", result.last_day, want.last_day);
				if (result.leap_year !== want.leap_year)
					report_mismatch("leap_year", result.leap_year, want.leap_year);
				if (result.date_valid !== want.date_valid)
					report_mismatch("date_valid", result.date_valid, want.date_valid);
			end
		end
	end

	// Guard against a hang. The limit is far beyond the slowest correct run.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("calendar_date_register_unit test failed");
			$finish;
		end
	end

	initial begin
		offer_t o;
		plan_row_t row;
		// Queue the directed table first and the random beats after it. The
		// sender then walks this queue.
		for (int i = 0; i < PLAN_ROWS; i++) begin
			row = PLAN[i];
			o.beat.action       = row.act;
			o.beat.year_in      = row.yr;
			o.beat.month_in     = row.mo;
			o.beat.day_in       = row.dy;
			o.beat.signature_in = row.sig;
			o.known = row.known;
			o.want  = date_result(row.want_year, row.want_month, row.want_day,
				row.want_last, row.want_leap, row.want_valid);
			date_offers.push_back(o);
		end
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			o.beat  = random_beat();
			o.known = 1'b0;
			date_offers.push_back(o);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every beat has gone in and every result has come back. Then
		// wait out the latency so that any extra result is still caught.
		while (date_offers.size() != 0 || pending_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0) begin
			$display("calendar_date_register_unit test passed");
		end else begin
			$display("calendar_date_register_unit test failed");
		end
		$finish;
	end

endmodule
